// ===== rtl/ltf_pkg.sv =====
// shared types and constants for the looper track transport fader
// mode and command codes, shared unit command and response words
// no dependencies
package ltf_pkg;

  // track modes
  localparam logic [3:0] MODE_EMPTY    = 4'd0;
  localparam logic [3:0] MODE_REC      = 4'd1;
  localparam logic [3:0] MODE_FINISH   = 4'd2;
  localparam logic [3:0] MODE_PRIMING  = 4'd3;
  localparam logic [3:0] MODE_STOPPED  = 4'd4;
  localparam logic [3:0] MODE_PLAY     = 4'd5;
  localparam logic [3:0] MODE_MUTED    = 4'd6;
  localparam logic [3:0] MODE_FADE_IN  = 4'd7;
  localparam logic [3:0] MODE_FADE_OUT = 4'd8;

  // commands
  localparam logic [3:0] OP_PULL       = 4'd0;
  localparam logic [3:0] OP_PLAY       = 4'd1;
  localparam logic [3:0] OP_STOP       = 4'd2;
  localparam logic [3:0] OP_MUTE       = 4'd3;
  localparam logic [3:0] OP_ERASE      = 4'd4;
  localparam logic [3:0] OP_START_REC  = 4'd5;
  localparam logic [3:0] OP_STOP_REC   = 4'd6;
  localparam logic [3:0] OP_FLUSH_DONE = 4'd7;
  localparam logic [3:0] OP_PRIMED     = 4'd8;

  // unity gain in Q1.15
  localparam logic [16:0] UNITY = 17'd32768;

  // steps of the shared shift-add / shift-subtract unit
  localparam int STEP_COUNT = 16;

  // command to the shared unit: multiply a*b>>15, or divide b/a
  typedef struct packed {
    logic        start;
    logic        div;
    logic [15:0] a;
    logic [15:0] b;
  } unit_cmd_t;

  // response from the shared unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] result;
  } unit_rsp_t;

endpackage

// ===== rtl/looper_track_transport_fader.sv =====
// looper track transport fader: one word in, one word out, per-track fades
// sequence: plain commands and out-of-range tracks go straight from accept to commit;
// fading pulls and fade starts first run the 16-step shared unit, then capture and commit
// a new word is taken only after the last is committed, later while a result word waits
// reset (synchronous, active high): every track empty, follow mode stopped,
// gain, step and fade count zero; fade_length 256
module looper_track_transport_fader import ltf_pkg::*; #(
  parameter int TRACKS = 9
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        fade_length,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         operation,
  input  logic [3:0]         track_index,
  input  logic signed [15:0] stored_sample,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               head_advanced,
  output logic [3:0]         track_mode,
  output logic               index_valid
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  // per-track state
  logic [3:0]  mode_tab   [TRACKS];
  logic [3:0]  follow_tab [TRACKS];
  logic [15:0] gain_tab   [TRACKS];
  logic [15:0] step_tab   [TRACKS];
  logic [15:0] left_tab   [TRACKS];

  logic [15:0] fade_len;
  logic [15:0] eff_len;

  // current word
  logic [3:0]        cur_op;
  logic [TW-1:0]     cur_idx;
  logic              cur_valid;
  logic signed [15:0] cur_sample;
  logic [15:0]       cur_res;

  unit_cmd_t cmd;
  unit_rsp_t rsp;

  // true when the command needs the shared unit in this mode
  function automatic logic uses_unit(input logic [3:0] op, input logic [3:0] m);
    logic r;
    r = 1'b0;
    if (op == OP_PULL && (m == MODE_FADE_IN || m == MODE_FADE_OUT)) r = 1'b1;
    if (op == OP_PLAY && (m == MODE_STOPPED || m == MODE_MUTED)) r = 1'b1;
    if (op == OP_STOP && (m == MODE_PLAY || m == MODE_MUTED || m == MODE_FADE_IN)) r = 1'b1;
    if (op == OP_MUTE && (m == MODE_PLAY || m == MODE_FADE_IN)) r = 1'b1;
    if (op == OP_FLUSH_DONE && m == MODE_FINISH) r = 1'b1;
    return r;
  endfunction

  // configuration register
  assign cfg_ready = 1'b1;
  assign eff_len   = (fade_len == 16'd0) ? 16'd1 : fade_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_len <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      fade_len <= fade_length;
    end
  end

  // lookup of the addressed track on the input side
  logic          in_range;
  logic [TW-1:0] in_idx;
  logic [3:0]    in_mode;
  logic [15:0]   in_gain;
  logic [15:0]   in_mag;
  logic          in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = ({1'b0, track_index} < 5'(TRACKS));
  assign in_idx   = track_index[TW-1:0];
  assign in_mode  = in_range ? mode_tab[in_idx] : MODE_EMPTY;
  assign in_gain  = in_range ? gain_tab[in_idx] : 16'd0;
  assign in_mag   = stored_sample[15] ? 16'(-stored_sample) : 16'(stored_sample);

  // start the shared unit
  always_comb begin
    cmd.start = in_acc && in_range && uses_unit(operation, in_mode);
    cmd.div   = (operation != OP_PULL);
    cmd.a     = in_mag;
    cmd.b     = in_gain;
    if (operation != OP_PULL) begin
      cmd.a = eff_len;
      unique case (operation)
        OP_PLAY:       cmd.b = 16'(UNITY - {1'b0, in_gain});
        OP_FLUSH_DONE: cmd.b = 16'(UNITY);
        default:       cmd.b = in_gain;
      endcase
    end
  end

  ltf_seq_unit u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_acc) begin
          state <= cmd.start ? S_RUN : S_DONE;
        end
        S_RUN: if (rsp.done) begin
          state <= S_DONE;
        end
        S_DONE: if (!out_valid || out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_op     <= operation;
      cur_idx    <= in_idx;
      cur_valid  <= in_range;
      cur_sample <= stored_sample;
    end
    if (state == S_RUN && rsp.done) begin
      cur_res <= rsp.result;
    end
  end

  // next row of the current track
  logic [3:0]  row_mode;
  logic [15:0] row_gain;
  logic [15:0] row_step;
  logic [15:0] row_left;
  logic [3:0]  nx_mode;
  logic [3:0]  nx_follow;
  logic [15:0] nx_gain;
  logic [15:0] nx_step;
  logic [15:0] nx_left;
  logic [15:0] res_sample;
  logic        res_adv;
  logic [16:0] gain_up;
  logic [15:0] left_dec;
  logic [15:0] gain_down;
  logic [15:0] scaled;

  assign row_mode  = mode_tab[cur_idx];
  assign row_gain  = gain_tab[cur_idx];
  assign row_step  = step_tab[cur_idx];
  assign row_left  = left_tab[cur_idx];
  assign gain_up   = {1'b0, row_gain} + {1'b0, row_step};
  assign left_dec  = (row_left != 16'd0) ? row_left - 16'd1 : 16'd0;
  assign gain_down = (row_step >= row_gain) ? 16'd0 : row_gain - row_step;
  assign scaled    = cur_sample[15] ? 16'd0 - cur_res : cur_res;

  always_comb begin
    nx_mode    = row_mode;
    nx_follow  = follow_tab[cur_idx];
    nx_gain    = row_gain;
    nx_step    = row_step;
    nx_left    = row_left;
    res_sample = 16'd0;
    res_adv    = 1'b0;
    case (cur_op) inside
      OP_PULL: begin
        if (row_mode == MODE_MUTED) begin
          res_adv = 1'b1;
        end else if (row_mode == MODE_PLAY || row_mode == MODE_FINISH) begin
          res_adv    = 1'b1;
          res_sample = cur_sample;
        end else if (row_mode == MODE_FADE_IN) begin
          res_adv    = 1'b1;
          res_sample = scaled;
          nx_left    = left_dec;
          nx_gain    = gain_up[15:0];
          if (left_dec == 16'd0 || gain_up >= UNITY) begin
            nx_gain = 16'(UNITY);
            nx_mode = MODE_PLAY;
          end
        end else if (row_mode == MODE_FADE_OUT) begin
          res_adv    = 1'b1;
          res_sample = scaled;
          nx_left    = left_dec;
          nx_gain    = gain_down;
          if (left_dec == 16'd0 || gain_down == 16'd0) begin
            nx_gain = 16'd0;
            nx_mode = follow_tab[cur_idx];
          end
        end
      end
      OP_PLAY: if (row_mode == MODE_STOPPED || row_mode == MODE_MUTED) begin
        nx_mode   = MODE_FADE_IN;
        nx_follow = MODE_PLAY;
        nx_left   = eff_len;
        nx_step   = cur_res;
      end
      OP_STOP: if (row_mode == MODE_PLAY || row_mode == MODE_MUTED ||
                   row_mode == MODE_FADE_IN) begin
        nx_mode   = MODE_FADE_OUT;
        nx_follow = MODE_PRIMING;
        nx_left   = eff_len;
        nx_step   = cur_res;
      end
      OP_MUTE: if (row_mode == MODE_PLAY || row_mode == MODE_FADE_IN) begin
        nx_mode   = MODE_FADE_OUT;
        nx_follow = MODE_MUTED;
        nx_left   = eff_len;
        nx_step   = cur_res;
      end
      OP_ERASE, OP_START_REC: begin
        nx_mode   = (cur_op == OP_START_REC) ? MODE_REC : MODE_EMPTY;
        nx_follow = MODE_STOPPED;
        nx_gain   = 16'd0;
        nx_step   = 16'd0;
        nx_left   = 16'd0;
      end
      OP_STOP_REC: if (row_mode == MODE_REC) begin
        nx_mode = MODE_FINISH;
      end
      OP_FLUSH_DONE: if (row_mode == MODE_FINISH) begin
        nx_mode   = MODE_FADE_IN;
        nx_follow = MODE_PLAY;
        nx_gain   = 16'd0;
        nx_left   = eff_len;
        nx_step   = cur_res;
      end
      OP_PRIMED: if (row_mode == MODE_PRIMING) begin
        nx_mode = MODE_STOPPED;
      end
      default: ;
    endcase
  end

  logic commit;
  assign commit = (state == S_DONE) && (!out_valid || out_ready);

  // track table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) begin
        mode_tab[i]   <= MODE_EMPTY;
        follow_tab[i] <= MODE_STOPPED;
        gain_tab[i]   <= 16'd0;
        step_tab[i]   <= 16'd0;
        left_tab[i]   <= 16'd0;
      end
    end else if (commit && cur_valid) begin
      mode_tab[cur_idx]   <= nx_mode;
      follow_tab[cur_idx] <= nx_follow;
      gain_tab[cur_idx]   <= nx_gain;
      step_tab[cur_idx]   <= nx_step;
      left_tab[cur_idx]   <= nx_left;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      sample_out    <= cur_valid ? res_sample : 16'sd0;
      head_advanced <= cur_valid & res_adv;
      track_mode    <= cur_valid ? nx_mode : MODE_EMPTY;
      index_valid   <= cur_valid;
    end
  end

  // checks
  unit_only_while_running: assert property (@(posedge clk) disable iff (rst)
    (rsp.busy || rsp.done) |-> state == S_RUN)
    else $error("shared unit active outside the run state");

  no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !rsp.busy)
    else $error("input ready while the shared unit is busy");

  result_follows_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word appeared without a finished word");

  bad_index_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !index_valid) |->
      (sample_out == 16'sd0 && !head_advanced && track_mode == MODE_EMPTY))
    else $error("out-of-range track produced a non-zero result");

endmodule

// ===== rtl/ltf_seq_unit.sv =====
// shared iterative arithmetic unit: one adder used for shift-add multiply
// (a*b >> 15) and restoring division (b / a), one bit per cycle
// depends on ltf_pkg
module ltf_seq_unit import ltf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_cmd_t cmd,
  output unit_rsp_t rsp
);

  localparam int CW = $clog2(STEP_COUNT);

  logic          busy;
  logic          done;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [31:0]   acc;
  logic [15:0]   shreg;
  logic [15:0]   opnd;

  logic [31:0] lhs;
  logic [32:0] rhs;
  logic [32:0] sum;
  logic        neg;

  // one adder: shifted accumulator plus operand, or partial remainder minus divisor
  always_comb begin
    if (is_div) begin
      lhs = {15'd0, acc[15:0], shreg[15]};
      rhs = 33'd0 - {17'd0, opnd};
    end else begin
      lhs = {acc[30:0], 1'b0};
      rhs = {17'd0, (shreg[15] ? opnd : 16'd0)};
    end
    sum = {1'b0, lhs} + rhs;
    neg = is_div & sum[32];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(STEP_COUNT - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      is_div <= cmd.div;
      opnd   <= cmd.a;
      shreg  <= cmd.b;
      acc    <= '0;
    end else if (busy) begin
      acc   <= neg ? lhs : sum[31:0];
      shreg <= {shreg[14:0], is_div & ~neg};
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = is_div ? shreg : acc[30:15];

endmodule
